// ----- hw/rtl/riit_pkg.sv -----
// Shared constants and command codes for the road incident impact table.
package riit_pkg;

  localparam int MAX_INCIDENTS_DEF = 64;
  localparam int ROAD_COUNT_DEF    = 1024;
  localparam int IMPACT_BITS_DEF   = 16;

  localparam int CMD_W       = 2;
  localparam int ROAD_IDX_W  = 10;
  localparam int IMPACT_IN_W = 16;
  localparam int INC_ID_W    = 6;
  localparam int TOTAL_W     = 22;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD    = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_QUERY  = 2'd2
  } cmd_t;

endpackage

// ----- hw/rtl/road_incident_impact_table_top.sv -----
// Top level of the road incident impact table: control, valid bits and query adder tree.
//
// Usage
// - Input channel: a transaction is taken at a rising edge with start high and busy low.
//   in_command selects add-run item, remove incident or query road total.
// - Result channel: out_valid marks each result for exactly one cycle; the receiver
//   cannot hold results off, so every result is delivered as soon as it is ready.
// - Remove, add items that set no membership bit, and unused command codes keep busy
//   low: one transaction per cycle, any result appears the cycle after acceptance.
// - An add item that sets a bit needs a read-modify-write of its road's membership row:
//   busy is high for one cycle while S_ADD_WR writes the row back, and the result comes from there.
// - A query reads the road's row from the membership RAM, then sums the masked impacts
//   through a fully registered adder tree of log2(MAX_INCIDENTS) levels: busy stays
//   high in S_QRY until node 1 holds the total, so a new query waits for the last one.
// - Mid-run add items answer nothing; command code 3 is ignored.
// - Reset: valid bits and the id counter clear at once, then a clearing pass writes
//   zero to every membership row (ROAD_COUNT rows, 1024 at the default), one row per
//   cycle. busy stays high throughout the pass.
module road_incident_impact_table_top #(
  parameter int MAX_INCIDENTS = riit_pkg::MAX_INCIDENTS_DEF,
  parameter int ROAD_COUNT    = riit_pkg::ROAD_COUNT_DEF,
  parameter int IMPACT_BITS   = riit_pkg::IMPACT_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic [riit_pkg::CMD_W-1:0]         in_command,
  input  logic [riit_pkg::ROAD_IDX_W-1:0]    in_road_index,
  input  logic                               in_road_present,
  input  logic [riit_pkg::IMPACT_IN_W-1:0]   in_impact_value,
  input  logic                               in_run_last,
  input  logic [riit_pkg::INC_ID_W-1:0]      in_removal_id,
  output logic                               out_valid,
  output logic                               out_status,
  output logic [riit_pkg::INC_ID_W-1:0]      out_assigned_id,
  output logic                               out_removed_count,
  output logic [riit_pkg::TOTAL_W-1:0]       out_total_impact
);

  import riit_pkg::*;

  localparam int ID_W  = $clog2(MAX_INCIDENTS);
  localparam int NID_W = $clog2(MAX_INCIDENTS + 1);
  localparam int RA_W  = $clog2(ROAD_COUNT);
  localparam int LV    = ID_W;
  localparam int LEAFS = 1 << ID_W;
  localparam int CNT_W = $clog2(LV + 1);

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_ADD_WR,
    S_QRY
  } state_t;

  state_t state_r, state_nxt;

  logic [NID_W-1:0]         next_id_r, next_id_nxt;
  logic [MAX_INCIDENTS-1:0] valid_r, valid_nxt;
  logic [RA_W-1:0]          clr_addr_r, clr_addr_nxt;
  logic [CNT_W-1:0]         cnt_r, cnt_nxt;

  logic                     out_valid_r, out_valid_nxt;
  logic                     out_status_r, out_status_nxt;
  logic [INC_ID_W-1:0]      out_assigned_id_r, out_assigned_id_nxt;
  logic                     out_removed_count_r, out_removed_count_nxt;
  logic [TOTAL_W-1:0]       out_total_impact_r, out_total_impact_nxt;

  // Pending add item, held across the read-modify-write
  logic [RA_W-1:0]          road_r;
  logic                     last_r;
  logic [IMPACT_BITS-1:0]   impact_pend_r;

  logic [IMPACT_BITS-1:0]   impact_r [MAX_INCIDENTS];
  logic                     imp_we;
  logic [IMPACT_BITS-1:0]   imp_wdata;

  logic                     ram_we;
  logic [RA_W-1:0]          ram_waddr;
  logic [MAX_INCIDENTS-1:0] ram_wdata;
  logic                     ram_re;
  logic [MAX_INCIDENTS-1:0] ram_rdata;

  logic                     accept;
  logic                     full;
  logic                     road_ok;
  logic                     rid_ok;
  logic                     finish_add;
  logic [MAX_INCIDENTS-1:0] id_bit;
  cmd_t                     cmd;

  logic [TOTAL_W-1:0]       leaf [LEAFS];
  logic [TOTAL_W-1:0]       tree_r [1:LEAFS-1];

  assign busy    = (state_r != S_IDLE);
  assign accept  = start && !busy;
  assign cmd     = cmd_t'(in_command);
  assign full    = (next_id_r == NID_W'(MAX_INCIDENTS));
  assign road_ok = (32'(in_road_index) < ROAD_COUNT);
  assign rid_ok  = (32'(in_removal_id) < MAX_INCIDENTS);
  assign id_bit  = {{(MAX_INCIDENTS-1){1'b0}}, 1'b1} << ID_W'(next_id_r);

  riit_ram #(
    .WIDTH (MAX_INCIDENTS),
    .DEPTH (ROAD_COUNT)
  ) u_membership (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (RA_W'(in_road_index)),
    .rdata (ram_rdata)
  );

  // Control: next state, valid bits, id counter and result registers
  always_comb begin
    state_nxt             = state_r;
    next_id_nxt           = next_id_r;
    valid_nxt             = valid_r;
    clr_addr_nxt          = clr_addr_r;
    cnt_nxt               = cnt_r;
    out_valid_nxt         = 1'b0;
    out_status_nxt        = out_status_r;
    out_assigned_id_nxt   = out_assigned_id_r;
    out_removed_count_nxt = out_removed_count_r;
    out_total_impact_nxt  = out_total_impact_r;
    ram_we                = 1'b0;
    ram_waddr             = clr_addr_r;
    ram_wdata             = '0;
    ram_re                = 1'b0;
    imp_we                = 1'b0;
    imp_wdata             = IMPACT_BITS'(in_impact_value);
    finish_add            = 1'b0;

    case (state_r)
      S_CLEAR: begin
        ram_we = 1'b1;
        if (clr_addr_r == RA_W'(ROAD_COUNT - 1)) begin
          state_nxt = S_IDLE;
        end else begin
          clr_addr_nxt = clr_addr_r + 1'b1;
        end
      end
      S_IDLE: begin
        if (accept) begin
          case (cmd)
            CMD_ADD: begin
              if (!full && in_road_present && road_ok) begin
                ram_re    = 1'b1;
                state_nxt = S_ADD_WR;
              end else if (in_run_last) begin
                finish_add = 1'b1;
              end
            end
            CMD_REMOVE: begin
              out_valid_nxt         = 1'b1;
              out_status_nxt        = 1'b0;
              out_assigned_id_nxt   = '0;
              out_total_impact_nxt  = '0;
              out_removed_count_nxt = 1'b0;
              if (rid_ok && valid_r[ID_W'(in_removal_id)]) begin
                valid_nxt[ID_W'(in_removal_id)] = 1'b0;
                out_removed_count_nxt           = 1'b1;
              end
            end
            CMD_QUERY: begin
              if (road_ok) begin
                ram_re    = 1'b1;
                cnt_nxt   = '0;
                state_nxt = S_QRY;
              end else begin
                out_valid_nxt         = 1'b1;
                out_status_nxt        = 1'b0;
                out_assigned_id_nxt   = '0;
                out_removed_count_nxt = 1'b0;
                out_total_impact_nxt  = '0;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_ADD_WR: begin
        ram_we     = 1'b1;
        ram_waddr  = road_r;
        ram_wdata  = ram_rdata | id_bit;
        imp_wdata  = impact_pend_r;
        finish_add = last_r;
        state_nxt  = S_IDLE;
      end
      S_QRY: begin
        if (cnt_r == CNT_W'(LV)) begin
          out_valid_nxt         = 1'b1;
          out_status_nxt        = 1'b0;
          out_assigned_id_nxt   = '0;
          out_removed_count_nxt = 1'b0;
          out_total_impact_nxt  = tree_r[1];
          state_nxt             = S_IDLE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // Close the add run: reject on a full table, else commit the new incident
    if (finish_add) begin
      out_valid_nxt         = 1'b1;
      out_removed_count_nxt = 1'b0;
      out_total_impact_nxt  = '0;
      if (full) begin
        out_status_nxt      = 1'b1;
        out_assigned_id_nxt = '0;
      end else begin
        out_status_nxt              = 1'b0;
        out_assigned_id_nxt         = INC_ID_W'(next_id_r);
        valid_nxt[ID_W'(next_id_r)] = 1'b1;
        next_id_nxt                 = next_id_r + 1'b1;
        imp_we                      = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      next_id_r   <= '0;
      valid_r     <= '0;
      clr_addr_r  <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      next_id_r   <= next_id_nxt;
      valid_r     <= valid_nxt;
      clr_addr_r  <= clr_addr_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload and pending add item
  always_ff @(posedge clk) begin
    out_status_r        <= out_status_nxt;
    out_assigned_id_r   <= out_assigned_id_nxt;
    out_removed_count_r <= out_removed_count_nxt;
    out_total_impact_r  <= out_total_impact_nxt;
    if (accept) begin
      road_r        <= RA_W'(in_road_index);
      last_r        <= in_run_last;
      impact_pend_r <= IMPACT_BITS'(in_impact_value);
    end
  end

  always_ff @(posedge clk) begin
    if (imp_we) begin
      impact_r[ID_W'(next_id_r)] <= imp_wdata;
    end
  end

  // Leaves: impact of each incident that is valid and on the row just read
  for (genvar i = 0; i < LEAFS; i++) begin : g_leaf
    if (i < MAX_INCIDENTS) begin : g_used
      assign leaf[i] = (ram_rdata[i] && valid_r[i]) ? TOTAL_W'(impact_r[i]) : '0;
    end else begin : g_pad
      assign leaf[i] = '0;
    end
  end

  // Heap-ordered adder tree, one register per level; node 1 is the total
  for (genvar n = 1; n < LEAFS; n++) begin : g_node
    logic [TOTAL_W-1:0] lhs;
    logic [TOTAL_W-1:0] rhs;
    if (2 * n >= LEAFS) begin : g_bottom
      assign lhs = leaf[2*n - LEAFS];
      assign rhs = leaf[2*n + 1 - LEAFS];
    end else begin : g_inner
      assign lhs = tree_r[2*n];
      assign rhs = tree_r[2*n + 1];
    end
    always_ff @(posedge clk) begin
      tree_r[n] <= lhs + rhs;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_assigned_id   = out_assigned_id_r;
  assign out_removed_count = out_removed_count_r;
  assign out_total_impact  = out_total_impact_r;

  // A result only follows an acceptance, a write-back or the end of a query
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ($past(accept) || $past(state_r == S_ADD_WR) ||
                     $past(state_r == S_QRY)))
    else $error("result without a cause");

  // No incident beyond the id counter is ever valid
  a_valid_below_next: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_CLEAR) |-> ((valid_r >> next_id_r) == '0))
    else $error("valid bit set at or above next id");

  a_next_id_bound: assert property (@(posedge clk) disable iff (!rst_n)
    next_id_r <= NID_W'(MAX_INCIDENTS))
    else $error("id counter past table size");

  // A rejected add reports nothing else
  a_full_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r) |->
      (out_assigned_id_r == '0 && out_removed_count_r == 1'b0 &&
       out_total_impact_r == '0))
    else $error("full status with payload");

  // Membership reads and writes never share a cycle, so no forwarding is needed
  a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(ram_we && ram_re))
    else $error("membership read and write in one cycle");

endmodule

// ----- hw/rtl/riit_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
module riit_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Hold read data until the next read.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- tb/tb_road_incident_impact_table_top.sv -----
// Self-checking testbench for the road incident impact table: stimulus, prediction and checks.
`timescale 1ns / 1ps

module tb_road_incident_impact_table_top;
  import riit_pkg::*;

  localparam int MAX_INC  = MAX_INCIDENTS_DEF;
  localparam int ROAD_N   = ROAD_COUNT_DEF;
  localparam int IMP_W    = IMPACT_BITS_DEF;
  localparam int N_ITEMS  = 1450;
  // Longest quiet stretch: the 1024-row clearing pass after reset, plus a full
  // sender gap and a query through the adder tree, taken a few times over.
  localparam int IDLE_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 32;
  // Command code 3 is not part of the package enum; the block ignores it.
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  typedef struct {
    logic                 status;
    logic [INC_ID_W-1:0]  assigned_id;
    logic                 removed_count;
    logic [TOTAL_W-1:0]   total_impact;
  } answer_t;

  // Mirror of the incident table and the queue of answers it should give.
  class incident_table_scoreboard;
    bit [MAX_INC-1:0] road_bits [ROAD_N];
    bit [IMP_W-1:0]   impact_mem [MAX_INC];
    bit [MAX_INC-1:0] live_ids;
    bit [7:0]         id_counter;
    bit               run_refused;
    answer_t          pending_answers [$];
    int               mismatches;
    int               n_added, n_full, n_removed, n_queries, n_nonzero, n_answers;

    task report(string msg);
      mismatches++;
      if (mismatches <= 30)
        $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    // Append one expected answer at the tail of the queue.
    function void queue_answer(answer_t a);
      pending_answers.insert(pending_answers.size(), a);
    endfunction

    // Note one accepted transaction and queue the answer it should produce.
    function void note_command(logic [CMD_W-1:0] cmd, logic [ROAD_IDX_W-1:0] road,
                               logic present, logic [IMPACT_IN_W-1:0] impact,
                               logic last, logic [INC_ID_W-1:0] rid);
      answer_t a;
      logic [TOTAL_W-1:0] sum;
      a = '{status: 1'b0, assigned_id: '0, removed_count: 1'b0, total_impact: '0};
      sum = '0;
      if (cmd == CMD_ADD) begin
        run_refused = (id_counter >= MAX_INC);
        if (!run_refused && present && road < ROAD_N)
          road_bits[road][id_counter] = 1'b1;
        if (last) begin
          if (run_refused) begin
            a.status = 1'b1;
            n_full++;
          end else begin
            impact_mem[id_counter] = impact[IMP_W-1:0];
            live_ids[id_counter] = 1'b1;
            a.assigned_id = id_counter[INC_ID_W-1:0];
            id_counter++;
            n_added++;
          end
          run_refused = 1'b0;
          queue_answer(a);
        end
      end else if (cmd == CMD_REMOVE) begin
        if (rid < MAX_INC && live_ids[rid]) begin
          live_ids[rid] = 1'b0;
          a.removed_count = 1'b1;
          n_removed++;
        end
        queue_answer(a);
      end else if (cmd == CMD_QUERY) begin
        if (road < ROAD_N)
          for (int i = 0; i < MAX_INC; i++)
            if (road_bits[road][i] && live_ids[i])
              sum = sum + TOTAL_W'(impact_mem[i]);
        a.total_impact = sum;
        n_queries++;
        if (sum != 0)
          n_nonzero++;
        queue_answer(a);
      end
    endfunction

    task check_answer(logic st, logic [INC_ID_W-1:0] id, logic rc,
                      logic [TOTAL_W-1:0] tot);
      answer_t e;
      n_answers++;
      if (pending_answers.size() == 0) begin
        report("result arrived with nothing expected");
      end else begin
        e = pending_answers.pop_front();
        if (st !== e.status)
          report($sformatf("status %0b, expected %0b", st, e.status));
        if (id !== e.assigned_id)
          report($sformatf("assigned_id %0d, expected %0d", id, e.assigned_id));
        if (rc !== e.removed_count)
          report($sformatf("removed_count %0b, expected %0b", rc, e.removed_count));
        if (tot !== e.total_impact)
          report($sformatf("total_impact %0d, expected %0d", tot, e.total_impact));
      end
    endtask
  endclass

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    start = 1'b0;
  logic                    busy;
  logic [CMD_W-1:0]        in_command = '0;
  logic [ROAD_IDX_W-1:0]   in_road_index = '0;
  logic                    in_road_present = 1'b0;
  logic [IMPACT_IN_W-1:0]  in_impact_value = '0;
  logic                    in_run_last = 1'b0;
  logic [INC_ID_W-1:0]     in_removal_id = '0;
  logic                    out_valid;
  logic                    out_status;
  logic [INC_ID_W-1:0]     out_assigned_id;
  logic                    out_removed_count;
  logic [TOTAL_W-1:0]      out_total_impact;

  incident_table_scoreboard sb = new;
  int items_sent;
  int burst_left;

  road_incident_impact_table_top uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_command        (in_command),
    .in_road_index     (in_road_index),
    .in_road_present   (in_road_present),
    .in_impact_value   (in_impact_value),
    .in_run_last       (in_run_last),
    .in_removal_id     (in_removal_id),
    .out_valid         (out_valid),
    .out_status        (out_status),
    .out_assigned_id   (out_assigned_id),
    .out_removed_count (out_removed_count),
    .out_total_impact  (out_total_impact)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Sample both channels at the rising edge. All inputs change only through
  // nonblocking updates, so the values seen here are those the block sees.
  // Check before noting: a transaction never answers in its own cycle.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid)
        sb.check_answer(out_status, out_assigned_id, out_removed_count, out_total_impact);
      if (start && !busy)
        sb.note_command(in_command, in_road_index, in_road_present, in_impact_value,
                        in_run_last, in_removal_id);
    end
  end

  // Watchdog: abort when nothing moves on either channel for too long.
  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if ((start && !busy) || out_valid)
        idle = 0;
      else
        idle++;
    end
    $display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
    $display("CHECK FAILED");
    $finish;
  end

  // Present one transaction and hold it until the block takes it. Start stays
  // high on return, so a back-to-back transaction needs no second update.
  task automatic send(logic [CMD_W-1:0] cmd, logic [ROAD_IDX_W-1:0] road,
                      logic present, logic [IMPACT_IN_W-1:0] impact, logic last,
                      logic [INC_ID_W-1:0] rid);
    int gap;
    // Mostly random idle gaps before each transaction, with occasional stretches of none.
    if (burst_left > 0) begin
      gap = 0;
      burst_left--;
    end else begin
      if ($urandom_range(0, 39) == 0)
        burst_left = $urandom_range(10, 40);
      gap = $urandom_range(0, 9);
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start           <= 1'b1;
    in_command      <= cmd;
    in_road_index   <= road;
    in_road_present <= present;
    in_impact_value <= impact;
    in_run_last     <= last;
    in_removal_id   <= rid;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (cmd != CMD_UNUSED)
      items_sent++;
  endtask

  // Most roads come from a small hot set so that incidents pile up on them
  // and queries return real sums; the rest span the whole index range.
  function automatic logic [ROAD_IDX_W-1:0] pick_road();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return 10'h155;
      3: return 10'h2AA;
      4: return 10'd7;
      5: return 10'd512;
      default: return ROAD_IDX_W'($urandom_range(0, ROAD_N - 1));
    endcase
  endfunction

  function automatic logic [INC_ID_W-1:0] pick_removal();
    int hi;
    hi = (sb.id_counter > MAX_INC) ? MAX_INC : int'(sb.id_counter);
    if (hi > 0 && $urandom_range(0, 2) != 0)
      return INC_ID_W'($urandom_range(0, hi - 1));
    return INC_ID_W'($urandom_range(0, 63));
  endfunction

  function automatic logic [IMPACT_IN_W-1:0] pick_impact();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return IMPACT_IN_W'($urandom());
    endcase
  endfunction

  task automatic random_query();
    send(CMD_QUERY, pick_road(), 1'($urandom_range(0, 1)), IMPACT_IN_W'($urandom()),
         1'($urandom_range(0, 1)), INC_ID_W'($urandom()));
  endtask

  task automatic random_remove();
    send(CMD_REMOVE, ROAD_IDX_W'($urandom()), 1'($urandom_range(0, 1)),
         IMPACT_IN_W'($urandom()), 1'($urandom_range(0, 1)), pick_removal());
  endtask

  // One add run of 1 to 4 items; now and then a query or removal is slipped in
  // mid-run to confirm the pending id stays invisible until the run closes.
  task automatic add_run();
    int len;
    logic last;
    len = $urandom_range(1, 4);
    for (int k = 0; k < len; k++) begin
      last = (k == len - 1);
      send(CMD_ADD, pick_road(), $urandom_range(0, 5) != 0, pick_impact(), last,
           INC_ID_W'($urandom()));
      if (!last && $urandom_range(0, 4) == 0) begin
        if ($urandom_range(0, 1) != 0)
          random_query();
        else
          random_remove();
      end
    end
  endtask

  initial begin : stimulus
    int pick;
    items_sent = 0;
    burst_left = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part: empty table, empty-list run, extreme fields, interleaving,
    // removal of live, dead and unknown ids, stale bits, ignored command code.
    send(CMD_QUERY,  10'd0,   1'b0, 16'h0000, 1'b0, 6'd0);
    send(CMD_REMOVE, 10'd0,   1'b0, 16'h0000, 1'b0, 6'd0);
    send(CMD_UNUSED, 10'd0,   1'b0, 16'h0000, 1'b0, 6'd0);
    send(CMD_ADD,    10'd0,   1'b0, 16'hFFFF, 1'b1, 6'd0);   // id 0, no roads
    send(CMD_ADD,    10'h3FF, 1'b1, 16'h1234, 1'b0, 6'd0);
    send(CMD_ADD,    10'd0,   1'b1, 16'h0000, 1'b0, 6'd0);
    send(CMD_ADD,    10'h155, 1'b0, 16'h5555, 1'b0, 6'd0);   // road not carried
    send(CMD_ADD,    10'd0,   1'b1, 16'hFFFF, 1'b1, 6'h3F);  // id 1
    send(CMD_ADD,    10'd5,   1'b1, 16'hAAAA, 1'b0, 6'd0);   // open run for id 2
    send(CMD_QUERY,  10'd5,   1'b1, 16'hFFFF, 1'b1, 6'h3F);  // pending id hidden
    send(CMD_REMOVE, 10'd5,   1'b1, 16'hFFFF, 1'b1, 6'd2);   // pending id not live
    send(CMD_ADD,    10'd5,   1'b1, 16'h8001, 1'b1, 6'd0);   // close id 2
    send(CMD_QUERY,  10'd5,   1'b0, 16'h0000, 1'b0, 6'd0);
    send(CMD_QUERY,  10'h3FF, 1'b0, 16'h0000, 1'b0, 6'd0);
    send(CMD_QUERY,  10'd0,   1'b0, 16'h0000, 1'b0, 6'd0);
    send(CMD_REMOVE, 10'd0,   1'b0, 16'h0000, 1'b0, 6'd1);   // live: removed
    send(CMD_REMOVE, 10'd0,   1'b0, 16'h0000, 1'b0, 6'd1);   // already gone
    send(CMD_QUERY,  10'd0,   1'b0, 16'h0000, 1'b0, 6'd0);   // stale bits ignored
    send(CMD_REMOVE, 10'h3FF, 1'b1, 16'hFFFF, 1'b1, 6'h3F);  // never allocated
    send(CMD_ADD,    10'd5,   1'b1, 16'h0000, 1'b1, 6'd0);   // zero impact
    send(CMD_QUERY,  10'd5,   1'b1, 16'h0000, 1'b0, 6'd0);
    send(CMD_UNUSED, 10'h3FF, 1'b1, 16'hFFFF, 1'b1, 6'h3F);
    send(CMD_QUERY,  10'h2AA, 1'b0, 16'h0000, 1'b0, 6'd0);

    // Random part. Add runs are rationed so that the table fills about half
    // way through; later runs then meet a full table.
    while (items_sent < N_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 14)
        add_run();
      else if (pick < 24)
        random_remove();
      else if (pick < 28)
        send(CMD_UNUSED, ROAD_IDX_W'($urandom()), 1'($urandom_range(0, 1)),
             IMPACT_IN_W'($urandom()), 1'($urandom_range(0, 1)), INC_ID_W'($urandom()));
      else
        random_query();
    end
    start <= 1'b0;

    // Drain: wait for every expected answer, then watch a little longer for
    // any stray result. The watchdog bounds both waits.
    while (sb.pending_answers.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.pending_answers.size() != 0)
      sb.report($sformatf("%0d expected results never arrived",
                          sb.pending_answers.size()));

    $display("%0d transactions, %0d results: %0d incidents added, %0d full-table answers",
             items_sent, sb.n_answers, sb.n_added, sb.n_full);
    $display("%0d removals took effect; %0d of %0d queries returned a non-zero total",
             sb.n_removed, sb.n_nonzero, sb.n_queries);
    if (sb.mismatches == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
